>>> rtl/core/sdg_pkg.sv
// Shared types and constants for the slot delta / gamma stream encoder.
// No dependencies; used by sdg_encode and slot_delta_gamma_encoder.
package sdg_pkg;

    // Element kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_SLOT    = 2'd0,
        REQ_GROUP   = 2'd1,
        REQ_OFFSET  = 2'd2,
        REQ_VERSION = 2'd3
    } req_type_t;

    // Count saturation limit (1..62)
    localparam logic [5:0] MAX_COUNT     = 6'd32;
    // Widest fingerprint sent in a group header
    localparam logic [5:0] FP_BITS_MAX   = 6'd32;
    localparam logic [5:0] FP_BITS_RESET = 6'd8;
    // Length of a raw first offset or version
    localparam logic [6:0] RAW_LEN       = 7'd32;
    // Gamma exponent whose code no longer fits one chunk
    localparam logic [5:0] GAMMA_K_SPLIT = 6'd32;

    // One output chunk
    typedef struct packed {
        logic [63:0] bits;
        logic [6:0]  len;
        logic        last;
    } chunk_t;

    // Everything one element produces: one or two chunks
    typedef struct packed {
        chunk_t first;
        chunk_t second;
        logic   two;
    } enc_result_t;

endpackage

>>> rtl/core/sdg_encode.sv
// Combinational coder for one element: unary counts, fingerprint headers,
// raw first values and Elias gamma of delta / zigzag deltas. Uses sdg_pkg.
module sdg_encode
#(
    parameter logic [5:0] MAX_COUNT = sdg_pkg::MAX_COUNT
)
(
    input  sdg_pkg::req_type_t   req_type,
    input  logic [5:0]           item_count,
    input  logic [31:0]          fingerprint,
    input  logic [31:0]          value,
    input  logic [31:0]          prev_value,
    input  logic                 is_first,
    input  logic [5:0]           fp_bits,
    output sdg_pkg::enc_result_t result
);

    logic [5:0]  cnt;
    logic [63:0] unary;
    logic [5:0]  fb;
    logic [63:0] fp_masked;
    logic [6:0]  hdr_total;
    logic [6:0]  cnt_len;
    logic [31:0] delta;
    logic [31:0] zigzag;
    logic [32:0] gval;
    logic [5:0]  gk;

    // Saturated count and its unary code: cnt ones then a zero
    always_comb
    begin
        cnt     = (item_count > MAX_COUNT) ? MAX_COUNT : item_count;
        cnt_len = {1'b0, cnt} + 7'd1;
        unary   = ((64'd1 << cnt) - 64'd1) << 1;
    end

    // Fingerprint width and masked fingerprint
    always_comb
    begin
        fb        = (fp_bits > sdg_pkg::FP_BITS_MAX) ? sdg_pkg::FP_BITS_MAX : fp_bits;
        fp_masked = {32'd0, fingerprint} & ((64'd1 << fb) - 64'd1);
        hdr_total = {1'b0, fb} + cnt_len;
    end

    // Gamma operand: delta for offsets, zigzag delta for versions, plus one in 33 bits
    always_comb
    begin
        delta  = prev_value - value;
        zigzag = {delta[30:0], 1'b0} ^ {32{delta[31]}};
        if (req_type == sdg_pkg::REQ_OFFSET)
            gval = {1'b0, delta} + 33'd1;
        else
            gval = {1'b0, zigzag} + 33'd1;
    end

    // Leading one position of the gamma operand
    always_comb
    begin
        gk = 6'd0;
        for (int i = 1; i < 33; i++)
        begin
            if (gval[i])
                gk = 6'(i);
        end
    end

    // Chunk selection per element kind
    always_comb
    begin
        result = '0;
        result.first.last = 1'b1;
        case (req_type)
            sdg_pkg::REQ_SLOT:
            begin
                result.first.bits = unary;
                result.first.len  = cnt_len;
            end
            sdg_pkg::REQ_GROUP:
            begin
                if (hdr_total <= 7'd64)
                begin
                    result.first.bits = (fp_masked << cnt_len) | unary;
                    result.first.len  = hdr_total;
                end
                else
                begin
                    // fingerprint and unary count as separate chunks
                    result.two         = 1'b1;
                    result.first.bits  = fp_masked;
                    result.first.len   = {1'b0, fb};
                    result.first.last  = 1'b0;
                    result.second.bits = unary;
                    result.second.len  = cnt_len;
                    result.second.last = 1'b1;
                end
            end
            sdg_pkg::REQ_OFFSET, sdg_pkg::REQ_VERSION:
            begin
                if (is_first)
                begin
                    result.first.bits = {32'd0, value};
                    result.first.len  = sdg_pkg::RAW_LEN;
                end
                else if (gk == sdg_pkg::GAMMA_K_SPLIT)
                begin
                    // 65-bit code: first 64 stream bits, then the final bit
                    result.two         = 1'b1;
                    result.first.bits  = {32'd0, gval[32:1]};
                    result.first.len   = 7'd64;
                    result.first.last  = 1'b0;
                    result.second.bits = {63'd0, gval[0]};
                    result.second.len  = 7'd1;
                    result.second.last = 1'b1;
                end
                else
                begin
                    result.first.bits = {31'd0, gval};
                    result.first.len  = {gk, 1'b1};
                end
            end
            default:
            begin
                result.first.bits = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/slot_delta_gamma_encoder.sv
// Slot delta / zigzag / Elias gamma stream encoder, top level.
// Depends on sdg_pkg and sdg_encode.
//
// Usage:
//   Elements of a slot enter on the s_ stream in format order: slot header,
//   then per group a group header, its offsets, then its versions. Each beat
//   produces one or two MSB-first chunks on the m_ stream; tlast marks the
//   final chunk of an element. The cfg channel writes fp_bits (always ready)
//   and is meant to be used only while the block is idle.
//   Path: an accepted beat passes the input register, then the result register.
//   Throughput: one element per cycle while m_tready stays high; an element
//   that splits into two chunks (long group header or 65-bit gamma code)
//   holds the output stage until its second, pending chunk is taken.
//   The input register takes a new beat while a finished chunk waits, so a
//   stalled receiver backs up through s_tready only once both stages fill.
//   Reset: fp_bits returns to 8, previous values to zero, the first-element
//   flags are set and both stages are emptied.
module slot_delta_gamma_encoder
#(
    parameter logic [5:0] MAX_COUNT = sdg_pkg::MAX_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,     // fp_bits
    // element input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,      // [5:0] item_count, [37:6] fingerprint, [69:38] value
    input  logic [1:0]  s_tuser,      // [1:0] req_type
    // chunk output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,      // [63:0] chunk_bits, [70:64] chunk_len
    output logic        m_tlast       // last_chunk
);

    // Configuration and element history
    logic [5:0]  fp_bits_reg,          fp_bits_next;
    logic [31:0] prev_offset_reg,      prev_offset_next;
    logic [31:0] prev_version_reg,     prev_version_next;
    logic        offset_first_reg,     offset_first_next;
    logic        version_first_reg,    version_first_next;

    // Input stage
    logic                 a_valid_reg,  a_valid_next;
    sdg_pkg::req_type_t   a_type_reg,   a_type_next;
    logic [5:0]           a_count_reg,  a_count_next;
    logic [31:0]          a_fp_reg,     a_fp_next;
    logic [31:0]          a_value_reg,  a_value_next;
    logic [31:0]          a_prev_reg,   a_prev_next;
    logic                 a_first_reg,  a_first_next;

    // Result stage: presented chunk plus an optional pending second one
    logic                 m_valid_reg,  m_valid_next;
    sdg_pkg::chunk_t      m_chunk_reg,  m_chunk_next;
    logic                 m_pend_reg,   m_pend_next;
    sdg_pkg::chunk_t      m_second_reg, m_second_next;

    sdg_pkg::req_type_t   in_type;
    sdg_pkg::enc_result_t enc;
    logic                 in_beat;
    logic                 load_b;

    assign in_type = sdg_pkg::req_type_t'(s_tuser);

    // Handshakes
    assign cfg_ready = 1'b1;
    assign load_b    = a_valid_reg && (!m_valid_reg || (m_tready && !m_pend_reg));
    assign s_tready  = !a_valid_reg || load_b;
    assign in_beat   = s_tvalid && s_tready;

    // Element coder between the two stages
    sdg_encode
    #(
        .MAX_COUNT   (MAX_COUNT)
    )
    u_encode
    (
        .req_type    (a_type_reg),
        .item_count  (a_count_reg),
        .fingerprint (a_fp_reg),
        .value       (a_value_reg),
        .prev_value  (a_prev_reg),
        .is_first    (a_first_reg),
        .fp_bits     (fp_bits_reg),
        .result      (enc)
    );

    // History update on each accepted beat; fp_bits on each cfg write
    always_comb
    begin
        fp_bits_next       = cfg_valid ? cfg_data : fp_bits_reg;
        prev_offset_next   = prev_offset_reg;
        prev_version_next  = prev_version_reg;
        offset_first_next  = offset_first_reg;
        version_first_next = version_first_reg;
        if (in_beat)
        begin
            case (in_type)
                sdg_pkg::REQ_SLOT, sdg_pkg::REQ_GROUP:
                begin
                    offset_first_next  = 1'b1;
                    version_first_next = 1'b1;
                end
                sdg_pkg::REQ_OFFSET:
                begin
                    offset_first_next = 1'b0;
                    prev_offset_next  = s_tdata[69:38];
                end
                sdg_pkg::REQ_VERSION:
                begin
                    version_first_next = 1'b0;
                    prev_version_next  = s_tdata[69:38];
                end
                default:
                begin
                    offset_first_next = offset_first_reg;
                end
            endcase
        end
    end

    // Input stage capture, with a snapshot of the matching history
    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_type_next  = a_type_reg;
        a_count_next = a_count_reg;
        a_fp_next    = a_fp_reg;
        a_value_next = a_value_reg;
        a_prev_next  = a_prev_reg;
        a_first_next = a_first_reg;
        if (in_beat)
        begin
            a_valid_next = 1'b1;
            a_type_next  = in_type;
            a_count_next = s_tdata[5:0];
            a_fp_next    = s_tdata[37:6];
            a_value_next = s_tdata[69:38];
            if (in_type == sdg_pkg::REQ_OFFSET)
            begin
                a_prev_next  = prev_offset_reg;
                a_first_next = offset_first_reg;
            end
            else
            begin
                a_prev_next  = prev_version_reg;
                a_first_next = version_first_reg;
            end
        end
        else if (load_b)
        begin
            a_valid_next = 1'b0;
        end
    end

    // Result stage: load a new element or step to the pending chunk
    always_comb
    begin
        m_valid_next  = m_valid_reg;
        m_chunk_next  = m_chunk_reg;
        m_pend_next   = m_pend_reg;
        m_second_next = m_second_reg;
        if (load_b)
        begin
            m_valid_next  = 1'b1;
            m_chunk_next  = enc.first;
            m_pend_next   = enc.two;
            m_second_next = enc.second;
        end
        else if (m_valid_reg && m_tready)
        begin
            if (m_pend_reg)
            begin
                m_chunk_next = m_second_reg;
                m_pend_next  = 1'b0;
            end
            else
            begin
                m_valid_next = 1'b0;
            end
        end
    end

    // Control and history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_bits_reg       <= sdg_pkg::FP_BITS_RESET;
            prev_offset_reg   <= '0;
            prev_version_reg  <= '0;
            offset_first_reg  <= 1'b1;
            version_first_reg <= 1'b1;
            a_valid_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
            m_pend_reg        <= 1'b0;
        end
        else
        begin
            fp_bits_reg       <= fp_bits_next;
            prev_offset_reg   <= prev_offset_next;
            prev_version_reg  <= prev_version_next;
            offset_first_reg  <= offset_first_next;
            version_first_reg <= version_first_next;
            a_valid_reg       <= a_valid_next;
            m_valid_reg       <= m_valid_next;
            m_pend_reg        <= m_pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_type_reg   <= a_type_next;
        a_count_reg  <= a_count_next;
        a_fp_reg     <= a_fp_next;
        a_value_reg  <= a_value_next;
        a_prev_reg   <= a_prev_next;
        a_first_reg  <= a_first_next;
        m_chunk_reg  <= m_chunk_next;
        m_second_reg <= m_second_next;
    end

    // Output beat
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_chunk_reg.len, m_chunk_reg.bits};
    assign m_tlast  = m_chunk_reg.last;

endmodule
